### hdl/dd_pose_pkg.sv
// shared constants, state type and arctangent table for the pose integrator
package dd_pose_pkg;

   localparam int CordicIterations = 16;
   localparam int CntWidth = $clog2(CordicIterations);
   localparam int DataWidth = 52;
   localparam int AngWidth = 34;
   localparam int MulAWidth = 35;
   localparam int MulBWidth = 33;
   localparam int ProdWidth = MulAWidth + MulBWidth;

   localparam logic [1:0] OpAdvance = 2'd0;
   localparam logic [1:0] OpLoad = 2'd1;

   localparam logic [23:0] TickReset = 24'd167772;
   localparam logic [31:0] GainQ32 = 32'd2608131497;
   localparam logic [29:0] GainQ30 = 30'd652032874;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001,
      S_HMUL = 12'b000000000010,
      S_SMUL = 12'b000000000100,
      S_GMUL = 12'b000000001000,
      S_RINIT = 12'b000000010000,
      S_RITER = 12'b000000100000,
      S_PUPD = 12'b000001000000,
      S_VINIT = 12'b000010000000,
      S_VITER = 12'b000100000000,
      S_MMUL = 12'b001000000000,
      S_MSAT = 12'b010000000000,
      S_DONE = 12'b100000000000
   } state_type;

   function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
      logic [29:0] r;
      case (idx)
         5'd0: r = 30'd536870912;
         5'd1: r = 30'd316933406;
         5'd2: r = 30'd167458907;
         5'd3: r = 30'd85004756;
         5'd4: r = 30'd42667331;
         5'd5: r = 30'd21354465;
         5'd6: r = 30'd10679838;
         5'd7: r = 30'd5340245;
         5'd8: r = 30'd2670163;
         5'd9: r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         5'd24: r = 30'd41;
         5'd25: r = 30'd20;
         5'd26: r = 30'd10;
         5'd27: r = 30'd5;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         5'd30: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

### hdl/diff_drive_pose_integrator_core.sv
// pose integrator top level: sequencer, shared multiplier and shared cordic stage
//
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | op, arg_x, arg_y, arg_heading, speed, turn_rate
// rsp     | out       | rsp_valid / rsp_stall | pos_x, pos_y, heading, distance, bearing
// csr     | in        | csr_wr_en             | tick_seconds (24 bits)
//
// an advance runs the multiplier steps, a rotation pass of CordicIterations steps through
// the single shift-add cordic stage, the pose update, a vectoring pass and the gain multiply;
// a query runs only the last two, which a load or a query at the pose itself skips.
// one item at a time: req_stall is high from the transfer until the result is taken.
// synchronous reset clears the pose and sets tick_seconds to its default. a stalled
// result holds until taken.
module diff_drive_pose_integrator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic signed [31:0] req_arg_x,
   input  logic signed [31:0] req_arg_y,
   input  logic [15:0] req_arg_heading,
   input  logic signed [31:0] req_speed,
   input  logic signed [31:0] req_turn_rate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic [15:0] rsp_heading,
   output logic [31:0] rsp_distance,
   output logic [15:0] rsp_bearing,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import dd_pose_pkg::*;

   state_type state_ff, state_in;
   logic [23:0] tick_ff;
   logic signed [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [31:0] pose_h_ff, pose_h_in;
   logic [1:0] op_ff;
   logic signed [31:0] ax_ff, ay_ff, spd_ff, rate_ff;
   logic signed [ProdWidth-1:0] prod_ff, prod_in;
   logic signed [DataWidth-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AngWidth-1:0] z_ff, z_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [31:0] dist_ff, dist_in;
   logic [15:0] bear_ff, bear_in;

   logic accept;
   logic last_iter;
   logic signed [MulAWidth-1:0] mul_a;
   logic signed [MulBWidth-1:0] mul_b;
   logic signed [DataWidth-1:0] xs, ys, d_val, vx0, vy0;
   logic signed [AngWidth-1:0] atan_val, z_rot0;
   logic sigma;
   logic [31:0] hp;
   logic signed [36:0] sum_x, sum_y;
   logic signed [32:0] dx, dy;
   logic signed [MulAWidth-1:0] xm;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_pos_x = pose_x_ff;
   assign rsp_pos_y = pose_y_ff;
   assign rsp_heading = pose_h_ff[31:16];
   assign rsp_distance = dist_ff;
   assign rsp_bearing = bear_ff;

   assign last_iter = (cnt_ff == CntWidth'(CordicIterations - 1));

   // shared cordic stage
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign atan_val = $signed({{(AngWidth - 30){1'b0}}, atan_lookup(5'(cnt_ff))});
   assign sigma = (state_ff == S_RITER) ? !z_ff[AngWidth-1] : y_ff[DataWidth-1];

   // rotation start values
   assign d_val = DataWidth'($signed(prod_ff[63:16]));
   assign hp = pose_h_ff + 32'h2000_0000;
   assign z_rot0 = $signed({{(AngWidth - 30){1'b0}}, hp[29:0]}) - AngWidth'(34'sh2000_0000);

   // vectoring start values
   assign dx = 33'(ax_ff) - 33'(pose_x_ff);
   assign dy = 33'(ay_ff) - 33'(pose_y_ff);
   assign vx0 = DataWidth'(dx) <<< 16;
   assign vy0 = DataWidth'(dy) <<< 16;

   assign sum_x = 37'(pose_x_ff) + 37'($signed(x_ff[51:16]));
   assign sum_y = 37'(pose_y_ff) + 37'($signed(y_ff[51:16]));
   assign xm = x_ff[DataWidth-1] ? '0 : MulAWidth'(x_ff[51:16]);

   always_comb begin
      unique case (state_ff)
         S_HMUL: begin
            mul_a = MulAWidth'(rate_ff);
            mul_b = $signed({9'd0, tick_ff});
         end
         S_SMUL: begin
            mul_a = MulAWidth'(spd_ff);
            mul_b = $signed({9'd0, tick_ff});
         end
         S_GMUL: begin
            mul_a = MulAWidth'($signed(prod_ff[55:24]));
            mul_b = $signed({1'b0, GainQ32});
         end
         default: begin
            mul_a = xm;
            mul_b = $signed({3'd0, GainQ30});
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pose_x_in = pose_x_ff;
      pose_y_in = pose_y_ff;
      pose_h_in = pose_h_ff;
      prod_in = prod_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cnt_in = cnt_ff;
      dist_in = dist_ff;
      bear_in = bear_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op == OpAdvance) begin
                  state_in = S_HMUL;
               end else begin
                  state_in = S_VINIT;
                  if (req_op == OpLoad) begin
                     pose_x_in = req_arg_x;
                     pose_y_in = req_arg_y;
                     pose_h_in = {req_arg_heading, 16'd0};
                  end
               end
            end
         end
         S_HMUL: begin
            prod_in = mul_a * mul_b;
            state_in = S_SMUL;
         end
         S_SMUL: begin
            pose_h_in = pose_h_ff + prod_ff[39:8];
            prod_in = mul_a * mul_b;
            state_in = S_GMUL;
         end
         S_GMUL: begin
            prod_in = mul_a * mul_b;
            state_in = S_RINIT;
         end
         S_RINIT: begin
            // quadrant pre-rotation
            case (hp[31:30])
               2'd0: begin
                  x_in = d_val;
                  y_in = '0;
               end
               2'd1: begin
                  x_in = '0;
                  y_in = d_val;
               end
               2'd2: begin
                  x_in = -d_val;
                  y_in = '0;
               end
               default: begin
                  x_in = '0;
                  y_in = -d_val;
               end
            endcase
            z_in = z_rot0;
            cnt_in = '0;
            state_in = S_RITER;
         end
         S_RITER, S_VITER: begin
            if (sigma) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_val;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last_iter) begin
               state_in = (state_ff == S_RITER) ? S_PUPD : S_MMUL;
            end
         end
         S_PUPD: begin
            if (sum_x > 37'sd2147483647) pose_x_in = 32'sh7fff_ffff;
            else if (sum_x < -37'sd2147483648) pose_x_in = 32'sh8000_0000;
            else pose_x_in = 32'(sum_x);
            if (sum_y > 37'sd2147483647) pose_y_in = 32'sh7fff_ffff;
            else if (sum_y < -37'sd2147483648) pose_y_in = 32'sh8000_0000;
            else pose_y_in = 32'(sum_y);
            state_in = S_VINIT;
         end
         S_VINIT: begin
            cnt_in = '0;
            if (dx == '0 && dy == '0) begin
               dist_in = '0;
               bear_in = '0;
               state_in = S_DONE;
            end else begin
               // left half plane starts half a turn around
               if (dx[32]) begin
                  x_in = -vx0;
                  y_in = -vy0;
                  z_in = AngWidth'(34'sh8000_0000);
               end else begin
                  x_in = vx0;
                  y_in = vy0;
                  z_in = '0;
               end
               state_in = S_VITER;
            end
         end
         S_MMUL: begin
            prod_in = mul_a * mul_b;
            bear_in = z_ff[31:16];
            state_in = S_MSAT;
         end
         S_MSAT: begin
            dist_in = (prod_ff[67:62] != '0) ? 32'hffff_ffff : prod_ff[61:30];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tick_ff <= TickReset;
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_h_ff <= '0;
      end else begin
         state_ff <= state_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         pose_h_ff <= pose_h_in;
         if (csr_wr_en) tick_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         ax_ff <= req_arg_x;
         ay_ff <= req_arg_y;
         spd_ff <= req_speed;
         rate_ff <= req_turn_rate;
      end
      prod_ff <= prod_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      cnt_ff <= cnt_in;
      dist_ff <= dist_in;
      bear_ff <= bear_in;
   end

   // pose only moves by load on an advance-free transfer
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VINIT && $past(state_ff) == S_IDLE && op_ff != OpLoad)
         |-> $stable(pose_x_ff))
      else $error("pose changed on a query");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result shown right after transfer");

   a_rsp_leaves: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (!rsp_valid && !req_stall))
      else $error("block did not return to idle after result transfer");

   a_iter_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RINIT || state_ff == S_VINIT) |=> cnt_ff == '0)
      else $error("cordic counter not cleared");

endmodule

### tb/tb_diff_drive_pose_integrator_core.sv
// testbench for the pose integrator core: directed table, random phases, result scoreboard
module tb_diff_drive_pose_integrator_core;
   import dd_pose_pkg::*;

   localparam logic [1:0] OpQuery = 2'd2;
   localparam logic [1:0] OpSpare = 2'd3;
   localparam int CycleLimit = 600000;
   localparam int RandomPerPhase = 190;
   localparam int HoldCycles = 400;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [15:0] hd;
      logic [31:0] dlen;
      logic [15:0] brg;
   } pose_res_type;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] ax;
      logic [31:0] ay;
      logic [15:0] ah;
      logic [31:0] spd;
      logic [31:0] rate;
      bit          typed;
      pose_res_type res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_op = OpQuery;
   logic signed [31:0] req_arg_x = '0;
   logic signed [31:0] req_arg_y = '0;
   logic [15:0] req_arg_heading = '0;
   logic signed [31:0] req_speed = '0;
   logic signed [31:0] req_turn_rate = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic [15:0] rsp_heading;
   logic [31:0] rsp_distance;
   logic [15:0] rsp_bearing;
   logic csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   diff_drive_pose_integrator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_arg_x(req_arg_x), .req_arg_y(req_arg_y),
      .req_arg_heading(req_arg_heading), .req_speed(req_speed),
      .req_turn_rate(req_turn_rate),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_heading(rsp_heading),
      .rsp_distance(rsp_distance), .rsp_bearing(rsp_bearing),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow pose and tick
   longint est_x = 0;
   longint est_y = 0;
   logic [31:0] est_hd = '0;
   logic [23:0] est_tick = TickReset;

   pose_res_type pose_q[$];
   int err_cnt = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_go = 1'b0;
   int hold_cnt = 0;
   int cycle_cnt = 0;

   longint arctan_steps[32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
   };

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic pose_res_type integrate_pose(logic [1:0] op, logic [31:0] ax,
                                                   logic [31:0] ay, logic [15:0] ah,
                                                   logic [31:0] spd, logic [31:0] rate);
      longint prod, d, cx, cy, cz, nx, pxl, pyl, dx, dy;
      logic [31:0] hsum;
      logic [63:0] mag;
      pose_res_type r;
      pxl = longint'($signed(ax));
      pyl = longint'($signed(ay));
      if (op == OpAdvance) begin
         prod = longint'($signed(rate)) * longint'(est_tick);
         est_hd = est_hd + prod[39:8];
         prod = longint'($signed(spd)) * longint'(est_tick);
         d = ((prod >>> 24) * 64'sd2608131497) >>> 16;
         hsum = est_hd + 32'h20000000;
         cz = longint'({2'b00, hsum[29:0]}) - 64'sh20000000;
         case (hsum[31:30])
            2'd0: begin cx = d; cy = 0; end
            2'd1: begin cx = 0; cy = d; end
            2'd2: begin cx = -d; cy = 0; end
            default: begin cx = 0; cy = -d; end
         endcase
         for (int i = 0; i < CordicIterations; i++) begin
            if (cz >= 0) begin
               nx = cx - (cy >>> i); cy = cy + (cx >>> i); cz -= arctan_steps[i];
            end else begin
               nx = cx + (cy >>> i); cy = cy - (cx >>> i); cz += arctan_steps[i];
            end
            cx = nx;
         end
         est_x = clamp32(est_x + (cx >>> 16));
         est_y = clamp32(est_y + (cy >>> 16));
      end else if (op == OpLoad) begin
         est_x = pxl;
         est_y = pyl;
         est_hd = {ah, 16'h0000};
      end
      dx = pxl - est_x;
      dy = pyl - est_y;
      r.px = est_x[31:0];
      r.py = est_y[31:0];
      r.hd = est_hd[31:16];
      r.dlen = '0;
      r.brg = '0;
      if (dx != 0 || dy != 0) begin
         cx = dx * 65536;
         cy = dy * 65536;
         cz = 0;
         if (dx < 0) begin
            cx = -cx; cy = -cy; cz = 64'sd2147483648;
         end
         for (int i = 0; i < CordicIterations; i++) begin
            if (cy >= 0) begin
               nx = cx + (cy >>> i); cy = cy - (cx >>> i); cz += arctan_steps[i];
            end else begin
               nx = cx - (cy >>> i); cy = cy + (cx >>> i); cz -= arctan_steps[i];
            end
            cx = nx;
         end
         if (cx < 0) cx = 0;
         mag = (64'(cx >>> 16) * 64'd652032874) >> 30;
         r.dlen = (mag > 64'hFFFFFFFF) ? 32'hFFFFFFFF : mag[31:0];
         r.brg = cz[31:16];
      end
      return r;
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         err_cnt++;
         if (err_cnt <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // result side: scoreboard, random stall and long hold-off
   always @(posedge clock) begin
      pose_res_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pose_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= 10) $display("result transfer with nothing expected");
         end else begin
            w = pose_q.pop_front();
            report_field("pos_x", w.px, rsp_pos_x);
            report_field("pos_y", w.py, rsp_pos_y);
            report_field("heading", {16'h0, w.hd}, {16'h0, rsp_heading});
            report_field("distance", w.dlen, rsp_distance);
            report_field("bearing", {16'h0, w.brg}, {16'h0, rsp_bearing});
         end
      end
      if (hold_go) begin
         hold_go = 1'b0;
         hold_cnt <= HoldCycles;
         rsp_stall <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CycleLimit) begin
         $display("tb_diff_drive_pose_integrator_core NOT OK");
         $finish;
      end
   end

   // offer one item and wait for its transfer; prediction is taken at the transfer
   task automatic send_item(stim_row_type row);
      pose_res_type r;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= row.op;
      req_arg_x <= row.ax;
      req_arg_y <= row.ay;
      req_arg_heading <= row.ah;
      req_speed <= row.spd;
      req_turn_rate <= row.rate;
      do @(posedge clock); while (req_stall !== 1'b0);
      r = integrate_pose(row.op, row.ax, row.ay, row.ah, row.spd, row.rate);
      pose_q.push_back(row.typed ? row.res : r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_tick(logic [23:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      est_tick = v;
   endtask

   function automatic logic [31:0] pick_word();
      int k;
      k = $urandom_range(99);
      if (k < 25) return $urandom;
      if (k < 40) begin
         case ($urandom_range(4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hFFFFFFFF;
            default: return 32'h00000001;
         endcase
      end
      return 32'($signed($urandom_range(2097151)) - 1048576);
   endfunction

   stim_row_type dir_rows[16] = '{
      '{OpQuery, 32'h0, 32'h0, 16'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 16'h0, 32'h0, 16'h0}},
      '{OpQuery, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OpQuery, 32'h80000000, 32'h80000000, 16'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OpQuery, 32'h80000000, 32'h7FFFFFFF, 16'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OpAdvance, 32'h0, 32'h0, 16'h0, 32'h7FFFFFFF, 32'h0, 1'b0, '0},
      '{OpAdvance, 32'h0, 32'h0, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, '0},
      '{OpAdvance, 32'h10000, 32'hFFFF0000, 16'h0, 32'h1234, 32'h80000000, 1'b0, '0},
      '{OpLoad, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 32'h0, 32'h0, 1'b1,
        '{32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 32'h0, 16'h0}},
      '{OpAdvance, 32'h0, 32'h0, 16'h0, 32'h7FFFFFFF, 32'h0, 1'b0, '0},
      '{OpQuery, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OpLoad, 32'h80000000, 32'h80000000, 16'h8000, 32'h0, 32'h0, 1'b1,
        '{32'h80000000, 32'h80000000, 16'h8000, 32'h0, 16'h0}},
      '{OpAdvance, 32'h0, 32'h0, 16'h0, 32'h7FFFFFFF, 32'h0, 1'b0, '0},
      '{OpLoad, 32'h12345678, 32'hFFFFFFFB, 16'h4000, 32'h0, 32'h0, 1'b1,
        '{32'h12345678, 32'hFFFFFFFB, 16'h4000, 32'h0, 16'h0}},
      '{OpSpare, 32'h12345678, 32'hFFFFFFFB, 16'h0, 32'h0, 32'h0, 1'b1,
        '{32'h12345678, 32'hFFFFFFFB, 16'h4000, 32'h0, 16'h0}},
      '{OpQuery, 32'h12355678, 32'hFFFFFFFB, 16'h0, 32'h0, 32'h0, 1'b0, '0},
      '{OpAdvance, 32'h0, 32'h0, 16'h0, 32'h10000, 32'h10000, 1'b0, '0}
   };

   initial begin
      stim_row_type row;
      logic [23:0] tick_set[5];
      int k;
      tick_set = '{TickReset, 24'h000000, 24'hFFFFFF, 24'h000001, 24'h0};
      tick_set[4] = 24'($urandom);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[j]) send_item(dir_rows[j]);
      for (int p = 0; p < 5; p++) begin
         drain();
         write_tick(tick_set[p]);
         case (p % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 85; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 85; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int n = 0; n < RandomPerPhase; n++) begin
            // in the first phase the result side holds off and the block stays occupied; in the second it drains once
            if (p == 0 && n == 20) hold_go = 1'b1;
            if (p == 1 && n == 50) begin
               req_valid <= 1'b0;
               while (pose_q.size() != 0) @(posedge clock);
            end
            k = $urandom_range(99);
            row.op = (k < 45) ? OpAdvance : (k < 60) ? OpLoad : (k < 92) ? OpQuery : OpSpare;
            row.ax = pick_word();
            row.ay = pick_word();
            row.ah = 16'($urandom);
            row.spd = pick_word();
            row.rate = ($urandom_range(3) == 0) ? $urandom : pick_word();
            row.typed = 1'b0;
            row.res = '0;
            send_item(row);
         end
      end
      req_valid <= 1'b0;
      while (pose_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (err_cnt == 0)
         $display("tb_diff_drive_pose_integrator_core OK");
      else
         $display("tb_diff_drive_pose_integrator_core NOT OK");
      $finish;
   end

endmodule
